FILE: design/ordered_array_list_macros.svh
// Assertion macros shared by the ordered array list RTL.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef ORDERED_ARRAY_LIST_MACROS_SVH
`define ORDERED_ARRAY_LIST_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define OAL_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ordered_array_list: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define OAL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_array_list: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_array_list: next-cycle check failed");

`endif

FILE: design/oal_pkg.sv
// Package for the ordered array list: sizes, command and status codes,
// transaction payload types and the controller-to-datapath command type.
// No dependencies.
`default_nettype none

package oal_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CMD_W     = 3;
    localparam int POS_W     = 5;
    localparam int STS_W     = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]            command;
        logic [POS_W-1:0]            position;
        logic signed [KEY_WIDTH-1:0] key_in;
    } t_oal_in;

    typedef struct packed {
        logic [STS_W-1:0]            status;
        logic signed [KEY_WIDTH-1:0] key_out;
        logic [CNT_W-1:0]            count;
    } t_oal_out;

    typedef struct packed {
        logic exec;
    } t_oal_cmd;

endpackage

`default_nettype wire

FILE: design/oal_dp.sv
// Datapath: chain of key cells with shift-up/shift-down/load per cell,
// entry counter, status decode and result register. Uses oal_pkg.
`default_nettype none

`include "ordered_array_list_macros.svh"

module oal_dp
    import oal_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_oal_cmd i_cmd,
    input  wire t_oal_in  i_req,
    output t_oal_out      o_res
);

    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    logic [KEY_WIDTH-1:0] r_cells [CAPACITY];
    logic [KEY_WIDTH-1:0] n_cells [CAPACITY];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    t_oal_out             r_res;
    t_oal_out             n_res;

    logic             full;
    logic             empty;
    logic             pos_in_list;
    logic             ins_pos_ok;
    logic             do_ins;
    logic             do_rem;
    logic             is_ins;
    logic [IDX_W-1:0] pos_slot;
    logic [IDX_W-1:0] ins_slot;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;

    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);
    assign pos_ext  = CMP_W'(i_req.position);
    assign cnt_ext  = CMP_W'(r_count);
    assign pos_slot = IDX_W'(i_req.position - 1'b1);
    assign pos_in_list = (i_req.position != '0) && (pos_ext <= cnt_ext);
    assign ins_pos_ok  = (i_req.position != '0) && (pos_ext <= cnt_ext + 1'b1);
    assign is_ins = (i_req.command == CMD_INSERT) || (i_req.command == CMD_HEAD)
                 || (i_req.command == CMD_TAIL);

    always_comb begin
        n_res.status  = STS_OK;
        n_res.key_out = '0;
        do_ins        = 1'b0;
        do_rem        = 1'b0;
        ins_slot      = '0;
        n_count       = r_count;
        unique case (i_req.command)
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_INSERT, CMD_HEAD, CMD_TAIL: begin
                if (i_req.command == CMD_INSERT) begin
                    ins_slot = pos_slot;
                end else if (i_req.command == CMD_TAIL) begin
                    ins_slot = IDX_W'(r_count);
                end
                if (full) begin
                    n_res.status = STS_FULL;
                end else if (i_req.command == CMD_INSERT && !ins_pos_ok) begin
                    n_res.status = STS_RANGE;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    n_res.status = STS_EMPTY;
                end else if (!pos_in_list) begin
                    n_res.status = STS_RANGE;
                end else begin
                    do_rem  = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_READ: begin
                if (empty) begin
                    n_res.status = STS_EMPTY;
                end else if (!pos_in_list) begin
                    n_res.status = STS_RANGE;
                end else begin
                    n_res.key_out = r_cells[pos_slot];
                end
            end
            default: begin
            end
        endcase
        n_res.count = n_count;
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
            if (do_ins) begin
                if (IDX_W'(i) == ins_slot) begin
                    n_cells[i] = i_req.key_in;
                end else if (i > 0 && IDX_W'(i) > ins_slot) begin
                    n_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
                end
            end else if (do_rem) begin
                if (i < CAPACITY - 1 && IDX_W'(i) >= pos_slot) begin
                    n_cells[i] = r_cells[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cells <= n_cells;
            r_res   <= n_res;
        end
    end

    assign o_res = r_res;

    `OAL_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `OAL_ASSERT_NEXT(a_full_reject, i_clk, i_rst_n, i_cmd.exec && is_ins && full, r_count == $past(r_count) && r_res.status == STS_FULL)
    `OAL_ASSERT_NEXT(a_clear_zero, i_clk, i_rst_n, i_cmd.exec && i_req.command == CMD_CLEAR, r_count == '0 && r_res.count == '0)

endmodule

`default_nettype wire

FILE: design/oal_ctrl.sv
// Controller: one-hot state machine tracking whether the result register
// holds an undelivered transaction; drives handshakes. Uses oal_pkg.
`default_nettype none

`include "ordered_array_list_macros.svh"

module oal_ctrl
    import oal_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_oal_cmd  o_cmd
);

    typedef enum logic [1:0] {
        CS_EMPTY = 2'b01,
        CS_HELD  = 2'b10
    } t_ctl_state;

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       accept;

    assign o_in_stall  = (r_state == CS_HELD) && i_out_stall;
    assign o_out_valid = (r_state == CS_HELD);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cmd.exec  = accept;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_EMPTY: begin
                if (accept) begin
                    n_state = CS_HELD;
                end
            end
            CS_HELD: begin
                if (accept) begin
                    n_state = CS_HELD;
                end else if (!i_out_stall) begin
                    n_state = CS_EMPTY;
                end
            end
            default: begin
                n_state = CS_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    `OAL_ASSERT_NEXT(a_accept_held, i_clk, i_rst_n, accept, r_state == CS_HELD)
    `OAL_ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, r_state == CS_HELD && i_out_stall, r_state == CS_HELD)
    `OAL_ASSERT_SAME(a_stall_only_held, i_clk, i_rst_n, o_in_stall, r_state == CS_HELD && !accept)

endmodule

`default_nettype wire

FILE: design/ordered_array_list.sv
// Channel   Dir  Handshake                 Payload
// request   in   i_in_valid / o_in_stall   i_in_data  (t_oal_in)
// result    out  o_out_valid / i_out_stall o_out_data (t_oal_out)
// One transaction per cycle unless the request side stalls: each request
// executes in the cycle it is accepted; the cell chain shifts all entries at once.
// Result appears the cycle after acceptance and stays until taken.
// Request side stalls only while a held result is stalled downstream.
// Synchronous active-low reset empties the list; no clearing pass.
// Top level: ordered array list; uses oal_pkg, oal_ctrl and oal_dp.
`default_nettype none

module ordered_array_list
    import oal_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_oal_in i_in_data,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_oal_out     o_out_data
);

    t_oal_cmd cmd;

    oal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    oal_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_data),
        .o_res   (o_out_data)
    );

endmodule

`default_nettype wire

FILE: tb/ordered_array_list_checker.sv
// Checker for the ordered array list: watches both channels, keeps a shadow
// copy of the list, predicts every result and compares it field by field.
// Depends on oal_pkg.
module ordered_array_list_checker
    import oal_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_stall,
    input  wire t_oal_in  i_in_data,
    input  wire logic     i_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_oal_out i_out_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_list_len
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [KEY_WIDTH-1:0] shadow_keys [CAPACITY];
    int                          shadow_len = 0;
    t_oal_out                    awaited_answers [$];
    int                          fails = 0;

    function automatic logic [STS_W-1:0] insert_key(int slot, logic signed [KEY_WIDTH-1:0] key);
        if (shadow_len >= CAPACITY) return STS_FULL;
        if (slot > shadow_len) return STS_RANGE;
        for (int i = shadow_len; i > slot; i--) shadow_keys[i] = shadow_keys[i - 1];
        shadow_keys[slot] = key;
        shadow_len++;
        return STS_OK;
    endfunction

    function automatic t_oal_out answer_request(t_oal_in req);
        t_oal_out ans;
        int       pos;
        ans = '0;
        pos = int'(req.position);
        case (req.command)
            CMD_CLEAR: begin
                shadow_len = 0;
            end
            CMD_INSERT: begin
                if (shadow_len >= CAPACITY) ans.status = STS_FULL;
                else if (pos < 1) ans.status = STS_RANGE;
                else ans.status = insert_key(pos - 1, req.key_in);
            end
            CMD_HEAD: begin
                ans.status = insert_key(0, req.key_in);
            end
            CMD_TAIL: begin
                ans.status = insert_key(shadow_len, req.key_in);
            end
            CMD_REMOVE, CMD_READ: begin
                if (shadow_len == 0) begin
                    ans.status = STS_EMPTY;
                end else if (pos < 1 || pos > shadow_len) begin
                    ans.status = STS_RANGE;
                end else if (req.command == CMD_READ) begin
                    ans.key_out = shadow_keys[pos - 1];
                end else begin
                    for (int i = pos - 1; i + 1 < shadow_len; i++)
                        shadow_keys[i] = shadow_keys[i + 1];
                    shadow_len--;
                end
            end
            default: begin
            end
        endcase
        ans.count = CNT_W'(shadow_len);
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_oal_out got;
        t_oal_out want;
        if (!i_rst_n) begin
            shadow_len = 0;
            awaited_answers.delete();
        end else begin
            // retire the result before queueing a request taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (awaited_answers.size() == 0) begin
                    $error("unexpected result transaction: status %0d key_out %0d count %0d",
                           got.status, got.key_out, got.count);
                    fails++;
                end else begin
                    want = awaited_answers.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.key_out !== want.key_out) begin
                        $error("key_out: expected %0d, actual %0d", want.key_out, got.key_out);
                        fails++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, got.count);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) awaited_answers.push_back(answer_request(i_in_data));
        end
        o_fail_count <= fails;
        o_pending    <= awaited_answers.size();
        o_list_len   <= shadow_len;
    end

endmodule

FILE: tb/testbench.sv
// Top of the ordered array list testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on oal_pkg, ordered_array_list and ordered_array_list_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import oal_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REQUEST_TARGET = 1150;
    localparam int LONG_HOLD      = 80;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef enum {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} t_phase;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    t_oal_in  req_data  = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    t_oal_out res_data;

    int fail_count;
    int pending;
    int list_len;

    bit calm         = 1'b0;
    int hold_seq     = 0;
    int hold_seen    = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int full_seen    = 0;
    int empty_seen   = 0;
    int range_seen   = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    ordered_array_list dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_data  (res_data)
    );

    ordered_array_list_checker answer_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_in_data    (req_data),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_out_data   (res_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_list_len   (list_len)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // result back-pressure; a bump of hold_seq forces one long hold
    always @(posedge clk) begin : backpressure
        int gap;
        if (!rst_n) begin
            res_stall  <= 1'b0;
            stall_left <= 0;
            hold_seen  <= 0;
        end else if (hold_seq != hold_seen) begin
            hold_seen  <= hold_seq;
            res_stall  <= 1'b1;
            stall_left <= LONG_HOLD - 1;
        end else if (stall_left > 0) begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            gap = pick_gap();
            res_stall  <= (gap != 0);
            stall_left <= (gap > 0) ? gap - 1 : 0;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (res_valid && !res_stall) begin
                results_seen++;
                if (res_data.status == STS_FULL) full_seen++;
                if (res_data.status == STS_EMPTY) empty_seen++;
                if (res_data.status == STS_RANGE) range_seen++;
            end
            if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic offer(input logic [CMD_W-1:0] cmd, input int pos,
                         input logic signed [KEY_WIDTH-1:0] key);
        t_oal_in req;
        int      gap;
        req.command  = cmd;
        req.position = POS_W'(pos);
        req.key_in   = key;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_data  <= req;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        if (cmd <= CMD_READ) requests_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic t_oal_in make_request(t_phase ph);
        t_oal_in req;
        int      roll;
        roll = $urandom_range(0, 99);
        req.position = POS_W'($urandom_range(0, 31));
        case ($urandom_range(0, 15))
            0:       req.key_in = 32'sh80000000;
            1:       req.key_in = 32'sh7fffffff;
            2:       req.key_in = -1;
            3:       req.key_in = 0;
            default: req.key_in = $urandom();
        endcase
        case (ph)
            PH_GROW: begin
                if (roll < 40) req.command = CMD_INSERT;
                else if (roll < 60) req.command = CMD_HEAD;
                else if (roll < 85) req.command = CMD_TAIL;
                else if (roll < 95) req.command = CMD_READ;
                else req.command = CMD_REMOVE;
            end
            PH_SHRINK: begin
                if (roll < 60) req.command = CMD_REMOVE;
                else if (roll < 85) req.command = CMD_READ;
                else if (roll < 95) req.command = CMD_INSERT;
                else req.command = CMD_TAIL;
            end
            PH_MIXED: begin
                if (roll < 20) req.command = CMD_INSERT;
                else if (roll < 35) req.command = CMD_HEAD;
                else if (roll < 50) req.command = CMD_TAIL;
                else if (roll < 75) req.command = CMD_REMOVE;
                else if (roll < 98) req.command = CMD_READ;
                else req.command = CMD_CLEAR;
            end
            default: begin
                req.command = CMD_W'($urandom_range(0, 7));
            end
        endcase
        // mostly legal positions outside the noise phase
        if (ph != PH_NOISE && $urandom_range(0, 9) != 0) begin
            if (req.command == CMD_REMOVE || req.command == CMD_READ)
                req.position = POS_W'((list_len > 0) ? $urandom_range(1, list_len) : 1);
            else
                req.position = POS_W'($urandom_range(1, list_len + 1));
        end
        return req;
    endfunction

    initial begin
        t_oal_in req;
        t_phase  ph;
        int      phase_no;
        int      roll;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        offer(CMD_READ, 1, 0);
        offer(CMD_REMOVE, 1, 0);
        offer(CMD_INSERT, 0, 5);
        offer(CMD_INSERT, 2, 5);
        offer(CMD_INSERT, 1, 32'sh80000000);
        offer(CMD_TAIL, 31, 32'sh7fffffff);
        offer(CMD_HEAD, 0, -1);
        offer(CMD_INSERT, 4, 0);
        offer(CMD_INSERT, 2, 32'sh5a5a5a5a);
        offer(CMD_READ, 0, 0);
        offer(CMD_READ, 6, 0);
        offer(CMD_READ, 31, 0);
        for (int p = 1; p <= 5; p++) offer(CMD_READ, p, 0);
        offer(CMD_REMOVE, 5, 0);
        offer(CMD_REMOVE, 1, 0);
        offer(CMD_REMOVE, 0, 0);
        offer(CMD_REMOVE, 9, 0);
        offer(CMD_SPARE_A, 3, 1);
        offer(CMD_SPARE_B, 31, -1);
        offer(CMD_CLEAR, 0, 0);
        offer(CMD_READ, 1, 0);
        wait_drained();

        phase_no = 0;
        while (requests_sent < REQUEST_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) ph = PH_GROW;
            else if (roll < 65) ph = PH_SHRINK;
            else if (roll < 90) ph = PH_MIXED;
            else ph = PH_NOISE;
            if (phase_no == 4 || phase_no == 21) begin
                calm     <= 1'b1;
                hold_seq <= hold_seq + 1;
            end else begin
                calm <= ($urandom_range(0, 5) == 0);
            end
            repeat ($urandom_range(10, 40)) begin
                req = make_request(ph);
                offer(req.command, int'(req.position), req.key_in);
            end
            if (phase_no % 6 == 5) wait_drained();
            phase_no++;
        end

        wait_drained();
        repeat (4) @(posedge clk);
        $display("Summary: %0d list requests, %0d results checked in %0d phases",
                 requests_sent, results_seen, phase_no);
        $display("Summary: %0d full rejects, %0d empty, %0d out of range",
                 full_seen, empty_seen, range_seen);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
